@@ hw/rtl/mlst_pkg.sv @@
// Shared types and constants for the maximum line segment tree.
// Holds the item carried along the row of level cells and the cell states.
// Depends on nothing; every other file of the block imports it.
package mlst_pkg;

  // Default number of points covered by the tree.
  localparam int unsigned DEF_MAX_POINTS = 65536;

  // Field widths of the channels and the register.
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned ICPT_W  = 40;
  localparam int unsigned DOM_W   = 17;
  localparam int unsigned QX_W    = 17;
  localparam int unsigned VAL_W   = 51;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  // Internal widths, sized for the largest tree the block may be built for
  // (about a million points), so one item type serves every build.
  localparam int unsigned PT_W    = 21;
  localparam int unsigned NODE_W  = 22;
  localparam int unsigned DK_W    = SLOPE_W + 1;
  localparam int unsigned DB_W    = ICPT_W + 1;
  localparam int unsigned PROD_W  = DK_W + PT_W + 1;
  localparam int unsigned DIFF_W  = PROD_W + 1;

  // Register index of the domain size.
  localparam int unsigned REG_DOMAIN_SIZE = 0;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } line_t;

  // One item as it walks down the tree, one level per cell.
  typedef struct packed {
    op_t                      op;
    logic                     active;
    line_t                    line;
    logic [PT_W-1:0]          x;
    logic [PT_W-1:0]          lo;
    logic [PT_W-1:0]          hi;
    logic [NODE_W-1:0]        node;
    logic signed [DIFF_W-1:0] best;
  } item_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SWEEP,
    C_READ,
    C_DIFF,
    C_MUL,
    C_ADD,
    C_DEC,
    C_DONE
  } cell_state_t;

endpackage

@@ hw/rtl/mlst_cell.sv @@
// One tree level: the node store of that level and the step that visits it.
// Items arrive from the level above and leave for the level below.
// Depends on mlst_pkg.
module mlst_cell #(
  parameter int unsigned LEVEL      = 0,
  parameter int unsigned NODE_COUNT = 2 * mlst_pkg::DEF_MAX_POINTS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlst_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output mlst_pkg::item_t out_item
);
  import mlst_pkg::*;

  localparam int unsigned DEPTH = 1 << LEVEL;
  localparam int unsigned AW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam logic [NODE_W-1:0] ADDR_MASK = NODE_W'(DEPTH - 1);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

  line_t mem [DEPTH];

  cell_state_t state, state_next;
  item_t       item, item_next;
  logic        has_item;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] addr;
  line_t       stored;
  logic signed [DK_W-1:0]   dk;
  logic signed [DB_W-1:0]   db;
  logic [PT_W-1:0]          mid;
  logic [PT_W-1:0]          pt_mid;
  logic signed [PROD_W-1:0] prod_lo, prod_mid, prod_hi;
  logic signed [DIFF_W-1:0] d_lo, d_mid, d_hi;
  logic signed [DIFF_W-1:0] value;
  logic in_active, leaf, wr_en;
  logic pos_lo, neg_lo, pos_mid, pos_hi, neg_hi, go_lo, go_hi;

  assign addr     = AW'(item.node & ADDR_MASK);
  assign leaf     = item.lo >= item.hi;
  assign pt_mid   = (item.op == OP_QUERY) ? item.x : mid;
  assign out_item = item;
  assign in_active = in_item.active && (in_item.node < NODE_W'(NODE_COUNT)) &&
                     (in_item.op == OP_INSERT || in_item.op == OP_QUERY);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.op == OP_CLEAR) state_next = C_SWEEP;
          else if (in_active)         state_next = C_READ;
          else                        state_next = C_DONE;
        end
      end
      C_SWEEP: begin
        if (sweep_addr == LAST_ADDR) state_next = has_item ? C_DONE : C_IDLE;
      end
      C_READ: state_next = C_DIFF;
      C_DIFF: state_next = C_MUL;
      C_MUL:  state_next = C_ADD;
      C_ADD:  state_next = C_DEC;
      C_DEC:  state_next = C_DONE;
      C_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  // Each difference is the carried line minus the stored one at that point.
  always_comb begin
    pos_lo  = !d_lo[DIFF_W-1] && (d_lo != '0);
    neg_lo  = d_lo[DIFF_W-1];
    pos_mid = !d_mid[DIFF_W-1] && (d_mid != '0);
    pos_hi  = !d_hi[DIFF_W-1] && (d_hi != '0);
    neg_hi  = d_hi[DIFF_W-1];
    value   = -d_mid;
    go_lo   = 1'b0;
    go_hi   = 1'b0;
    wr_en   = 1'b0;
    item_next = item;
    unique case (item.op)
      OP_QUERY: begin
        if (value > item.best) item_next.best = value;
        if (leaf) begin
          item_next.active = 1'b0;
        end else if (item.x <= mid) begin
          item_next.hi   = mid;
          item_next.node = {item.node[NODE_W-2:0], 1'b0};
        end else begin
          item_next.lo   = PT_W'(mid + 1'b1);
          item_next.node = {item.node[NODE_W-2:0], 1'b1};
        end
      end
      OP_INSERT: begin
        if (leaf) begin
          item_next.active = 1'b0;
          wr_en = pos_lo;
        end else begin
          // After a swap the carried and stored lines trade places, so the
          // signs of the end-point differences turn over.
          wr_en = pos_mid;
          if (pos_mid) item_next.line = stored;
          go_lo = pos_mid ? neg_lo : pos_lo;
          go_hi = pos_mid ? neg_hi : pos_hi;
          if (go_lo) begin
            item_next.hi   = mid;
            item_next.node = {item.node[NODE_W-2:0], 1'b0};
          end else if (go_hi) begin
            item_next.lo   = PT_W'(mid + 1'b1);
            item_next.node = {item.node[NODE_W-2:0], 1'b1};
          end else begin
            item_next.active = 1'b0;
          end
        end
      end
      default: item_next = item;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= C_SWEEP;
      has_item   <= 1'b0;
      sweep_addr <= '0;
    end else begin
      state <= state_next;
      if (state == C_IDLE && in_valid) has_item <= 1'b1;
      else if (state == C_DONE && out_ready) has_item <= 1'b0;
      if (state == C_SWEEP) sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && in_valid) begin
      item        <= in_item;
      item.active <= in_active;
    end else if (state == C_DEC) begin
      item <= item_next;
    end
    if (state == C_DIFF) begin
      dk  <= DK_W'(item.line.slope) - DK_W'(stored.slope);
      db  <= DB_W'(item.line.intercept) - DB_W'(stored.intercept);
      mid <= PT_W'(({1'b0, item.lo} + {1'b0, item.hi}) >> 1);
    end
    if (state == C_MUL) begin
      prod_lo  <= dk * $signed({1'b0, item.lo});
      prod_mid <= dk * $signed({1'b0, pt_mid});
      prod_hi  <= dk * $signed({1'b0, item.hi});
    end
    if (state == C_ADD) begin
      d_lo  <= DIFF_W'(prod_lo) + DIFF_W'(db);
      d_mid <= DIFF_W'(prod_mid) + DIFF_W'(db);
      d_hi  <= DIFF_W'(prod_hi) + DIFF_W'(db);
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_SWEEP) mem[sweep_addr] <= '0;
    else if (state == C_DEC && wr_en) mem[addr] <= item.line;
    if (state == C_READ) stored <= mem[addr];
  end

endmodule

@@ hw/rtl/max_line_segment_tree_unit.sv @@
// Top level of the maximum line segment tree: register port, row of level
// cells and the result register.
// Depends on mlst_pkg and mlst_cell.
//
// Use: set domain_size over the register port (byte address 0) while the block
// is idle. Items enter on in_valid/in_ready: func selects insert, query or
// clear; func 3 passes through and changes nothing. Only a query gives a
// result item, on out_valid/out_ready, carrying max_value.
// The tree is a row of cells, one per level, each with the store of its own
// level; an item walks down the row one cell at a time. A live visit to a
// cell steps through accept, read, difference, multiply, add, decide and
// hand-over; a visit after the walk has ended goes from accept straight to
// hand-over. There are 17 levels at the default size. Each cell holds one
// item, so a new item can enter once the first cell has handed its last one
// on, while earlier ones are still further down the row.
// A clear makes every cell sweep its store, one entry a cycle: a store of
// 2^level entries per cell, 65536 in the last cell at the default size.
// Reset starts the same sweep in every cell at once; the first cell, with a
// single entry, takes items when swept; they wait behind cells still sweeping.
// If the receiver stalls, a result waits in the output register while the
// row goes on taking items until the cells behind it fill.
module max_line_segment_tree_unit #(
  parameter int unsigned MAX_POINTS = mlst_pkg::DEF_MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlst_pkg::ADDR_W-1:0]       paddr,
  input  logic [mlst_pkg::DATA_W-1:0]       pwdata,
  output logic [mlst_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mlst_pkg::FUNC_W-1:0]       func,
  input  logic signed [mlst_pkg::SLOPE_W-1:0] line_slope,
  input  logic signed [mlst_pkg::ICPT_W-1:0]  line_intercept,
  input  logic [mlst_pkg::QX_W-1:0]         query_x,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mlst_pkg::VAL_W-1:0] max_value
);
  import mlst_pkg::*;

  // One level for each halving of the domain, plus the leaves.
  localparam int unsigned LEVELS     = $clog2(MAX_POINTS) + 1;
  localparam int unsigned NODE_COUNT = 2 * MAX_POINTS;

  logic [DOM_W-1:0] domain;
  logic [PT_W-1:0]  dom_ext, eff_domain;
  logic             reg_sel;
  op_t              head_op;
  logic             head_live;
  item_t            head;
  item_t            link_item [LEVELS+1];
  logic [LEVELS:0]  link_valid, link_ready;
  logic             tail_query, tail_take;

  // Register port. There is one register; the upper address bit picks it.
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1] == 1'(REG_DOMAIN_SIZE);
  assign prdata  = reg_sel ? DATA_W'(domain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain <= DOM_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      domain <= pwdata[DOM_W-1:0];
    end
  end

  // A domain of zero behaves as one point, and one beyond the store is cut
  // down to the largest tree the store holds.
  always_comb begin
    dom_ext = PT_W'(domain);
    if (dom_ext == '0) eff_domain = PT_W'(1);
    else if (dom_ext > PT_W'(MAX_POINTS)) eff_domain = PT_W'(MAX_POINTS);
    else eff_domain = dom_ext;
  end

  // A query carries the line 0,0 through the row, so each cell's difference
  // is the negated value of its stored line at the query point.
  always_comb begin
    head_op        = op_t'(func);
    head_live      = (head_op == OP_INSERT) || (head_op == OP_QUERY);
    head.op        = head_op;
    head.active    = head_live;
    head.line.slope     = (head_op == OP_INSERT) ? line_slope : '0;
    head.line.intercept = (head_op == OP_INSERT) ? line_intercept : '0;
    head.x         = PT_W'(query_x);
    head.lo        = PT_W'(1);
    head.hi        = eff_domain;
    head.node      = NODE_W'(1);
    head.best      = '0;
  end

  assign link_item[0]  = head;
  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    mlst_cell #(
      .LEVEL      (g),
      .NODE_COUNT (NODE_COUNT)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_item   (link_item[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_item  (link_item[g+1])
    );
  end

  // Items other than queries are simply dropped at the end of the row.
  assign tail_query         = link_item[LEVELS].op == OP_QUERY;
  assign link_ready[LEVELS] = !tail_query || !out_valid || out_ready;
  assign tail_take          = link_valid[LEVELS] && link_ready[LEVELS] && tail_query;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tail_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_take) max_value <= VAL_W'(link_item[LEVELS].best);
  end

  // A result only ever comes from a query leaving the last cell.
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tail_take))
    else $error("result item appeared without a query leaving the last level");

  // The maximum includes the empty baseline, so it is never negative.
  a_result_not_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !max_value[VAL_W-1])
    else $error("query result is negative");

  // Straight after reset the first level is still clearing its store.
  a_no_take_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("item taken before the store was cleared after reset");

endmodule

@@ test/max_line_segment_tree_unit_test.sv @@
// Self-checking testbench for max_line_segment_tree_unit: directed table, then random phases.
// Holds a line-tree predictor, the stimulus and the result checker.
// Depends on mlst_pkg and the block's RTL.
module max_line_segment_tree_unit_test;
  import mlst_pkg::*;

  // Tree size the block is built for, and its node count in heap order.
  localparam longint TREE_POINTS = DEF_MAX_POINTS;
  localparam longint TREE_NODES  = 2 * DEF_MAX_POINTS;

  // Quiet cycles after the last result: enough for every item still
  // walking the row of level cells.
  localparam int DRAIN_CYCLES = 400;
  // A clear sweeps every level store; the deepest holds 65536 entries. The
  // sweeps may run one after another down the row, so allow their sum.
  localparam longint SWEEP_CYCLES = 140000;
  // The watchdog fires after this many cycles without a handshake. The longest
  // quiet stretch in a correct run is a sweep followed by a drain.
  localparam int STUCK_LIMIT = 500000;

  localparam int PHASE_ITEMS = 56;

  localparam logic signed [SLOPE_W-1:0] K_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SLOPE_W-1:0] K_MIN = 32'sh8000_0000;
  localparam logic signed [ICPT_W-1:0]  B_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [ICPT_W-1:0]  B_MIN = 40'sh80_0000_0000;

  typedef enum logic {
    STEP_ITEM,
    STEP_DOMAIN
  } step_kind_e;

  // One row of the directed table. A row with a pinned value carries its
  // expected result; every other query is checked against the predictor.
  typedef struct packed {
    step_kind_e                kind;
    op_t                       op;
    logic signed [SLOPE_W-1:0] k;
    logic signed [ICPT_W-1:0]  b;
    logic [QX_W-1:0]           x;
    logic                      pinned;
    logic signed [VAL_W-1:0]   want;
    logic [DATA_W-1:0]         dom;
  } step_t;

  localparam step_t SCRIPT [25] = '{
    // Empty tree after reset, domain one: the zero baseline everywhere.
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd1,      1'b1, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd131071, 1'b1, 51'sd0,         32'd0},
    // A flat line at the largest intercept; a losing line changes nothing.
    '{STEP_ITEM,   OP_INSERT, 32'sd0,  B_MAX,       17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd1,      1'b1, 51'sd549755813887, 32'd0},
    '{STEP_ITEM,   OP_INSERT, -32'sd1, -40'sd5,     17'd0,      1'b0, 51'sd0,         32'd0},
    // A point outside the domain still ends at a leaf.
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd0,      1'b1, 51'sd549755813887, 32'd0},
    '{STEP_ITEM,   OP_CLEAR,  32'sd0,  40'sd0,      17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd1,      1'b1, 51'sd0,         32'd0},
    // The unused operation, with every field at its extreme.
    '{STEP_ITEM,   OP_NOP,    K_MAX,   B_MAX,       17'd131071, 1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_INSERT, K_MAX,   40'sd0,      17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd1,      1'b1, 51'sd2147483647, 32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd131071, 1'b0, 51'sd0,         32'd0},
    // Full domain over lines that were stored under domain one.
    '{STEP_DOMAIN, OP_NOP,    32'sd0,  40'sd0,      17'd0,      1'b0, 51'sd0,         32'd65536},
    '{STEP_ITEM,   OP_INSERT, K_MIN,   B_MAX,       17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_INSERT, K_MAX,   B_MIN,       17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_INSERT, 32'sd3,  40'sd10,     17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_INSERT, -32'sd3, 40'sd200000, 17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd1,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd65536,  1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd32768,  1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd131071, 1'b0, 51'sd0,         32'd0},
    // Domain zero behaves as one.
    '{STEP_DOMAIN, OP_NOP,    32'sd0,  40'sd0,      17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd1,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_INSERT, K_MIN,   B_MIN,       17'd0,      1'b0, 51'sd0,         32'd0},
    '{STEP_ITEM,   OP_QUERY,  32'sd0,  40'sd0,      17'd65535,  1'b0, 51'sd0,         32'd0}
  };

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func;
  logic signed [SLOPE_W-1:0] line_slope;
  logic signed [ICPT_W-1:0]  line_intercept;
  logic [QX_W-1:0]           query_x;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VAL_W-1:0]   max_value;

  // Predictor state: the stored line of each node, present only once written.
  longint tree_k [int unsigned];
  longint tree_b [int unsigned];
  logic [DOM_W-1:0] dom_reg = 17'd1;

  // Maxima still owed by the block, oldest first.
  logic signed [VAL_W-1:0] peak_queue [$];

  longint cycle_no = 0;
  longint last_clear_cycle = 0;
  int     stall_left = 0;
  int     stuck_cycles = 0;
  bit     steady_flow = 1'b0;
  int     fault_count = 0;
  int     n_insert = 0;
  int     n_query = 0;
  int     n_clear = 0;
  int     n_nop = 0;
  int     n_settings = 0;
  int     n_checked = 0;

  max_line_segment_tree_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .line_slope     (line_slope),
    .line_intercept (line_intercept),
    .query_x        (query_x),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .max_value      (max_value)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Points covered by the tree: a zero register acts as one, and anything
  // beyond the built size is held at that size.
  function automatic longint tree_span();
    if (dom_reg == 0) return 1;
    if (longint'(dom_reg) > TREE_POINTS) return TREE_POINTS;
    return longint'(dom_reg);
  endfunction

  function automatic longint line_at(longint k, longint b, longint x);
    return k * x + b;
  endfunction

  // Walk one root-to-leaf path. The line that is higher at the middle stays;
  // the other moves to the side where it is still higher, or is dropped.
  // Equal values always leave the stored line in place.
  function automatic void tree_insert(longint k, longint b);
    longint lo, hi, mid, sk, sb, tk, tb;
    int unsigned n;
    lo = 1;
    hi = tree_span();
    n = 1;
    while (longint'(n) < TREE_NODES) begin
      sk = tree_k.exists(n) ? tree_k[n] : 0;
      sb = tree_b.exists(n) ? tree_b[n] : 0;
      if (lo >= hi) begin
        if (line_at(k, b, lo) > line_at(sk, sb, lo)) begin
          tree_k[n] = k;
          tree_b[n] = b;
        end
        return;
      end
      mid = (lo + hi) / 2;
      if (line_at(k, b, mid) > line_at(sk, sb, mid)) begin
        tree_k[n] = k;
        tree_b[n] = b;
        tk = k;
        tb = b;
        k = sk;
        b = sb;
        sk = tk;
        sb = tb;
      end
      if (line_at(k, b, lo) > line_at(sk, sb, lo)) begin
        hi = mid;
        n = 2 * n;
      end else if (line_at(k, b, hi) > line_at(sk, sb, hi)) begin
        lo = mid + 1;
        n = 2 * n + 1;
      end else begin
        return;
      end
    end
  endfunction

  // Largest value at x over the nodes on the path to x, never below zero.
  function automatic longint tree_peak(longint x);
    longint lo, hi, mid, v, best;
    int unsigned n;
    lo = 1;
    hi = tree_span();
    n = 1;
    best = 0;
    while (longint'(n) < TREE_NODES) begin
      v = tree_k.exists(n) ? line_at(tree_k[n], tree_b[n], x) : 0;
      if (v > best) best = v;
      if (lo >= hi) break;
      mid = (lo + hi) / 2;
      if (x <= mid) begin
        hi = mid;
        n = 2 * n;
      end else begin
        lo = mid + 1;
        n = 2 * n + 1;
      end
    end
    return best;
  endfunction

  // Idle length for either side: none in a steady phase; otherwise mostly none,
  // sometimes a short idle, now and then a long pause.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Present one item and hold it until accepted, then update the predictor.
  // Valid stays high after acceptance so that back-to-back items need no
  // extra assignment; a gap lowers it first, in a step of its own.
  task automatic send_item(input op_t op, input logic signed [SLOPE_W-1:0] k,
                           input logic signed [ICPT_W-1:0] b, input logic [QX_W-1:0] x,
                           input logic pinned, input logic signed [VAL_W-1:0] want);
    int gap;
    longint peak;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= op;
    line_slope     <= k;
    line_intercept <= b;
    query_x        <= x;
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_INSERT: begin
        tree_insert(k, b);
        n_insert++;
      end
      OP_QUERY: begin
        peak = tree_peak(x);
        peak_queue.push_back(pinned ? want : peak[VAL_W-1:0]);
        n_query++;
      end
      OP_CLEAR: begin
        tree_k.delete();
        tree_b.delete();
        last_clear_cycle = cycle_no;
        n_clear++;
      end
      default: n_nop++;
    endcase
  endtask

  // Random item for a tree of span points. Most inserts are lines that cross
  // inside the domain, so that nodes swap and losers travel down the path.
  task automatic send_random(input longint span);
    int r;
    longint c, s, bb;
    logic signed [SLOPE_W-1:0] k;
    logic signed [ICPT_W-1:0]  b;
    logic [QX_W-1:0]           x;
    op_t op;
    r = $urandom_range(0, 99);
    k = $urandom;
    b = {8'($urandom), 32'($urandom)};
    x = 17'($urandom);
    if (r < 45) begin
      op = OP_INSERT;
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          case ($urandom_range(0, 3))
            0: k = K_MAX;
            1: k = K_MIN;
            2: k = 32'sd0;
            default: k = -32'sd1;
          endcase
          case ($urandom_range(0, 3))
            0: b = B_MAX;
            1: b = B_MIN;
            2: b = 40'sd0;
            default: b = -40'sd1;
          endcase
        end
        default: begin
          c = longint'($urandom_range(1, 32'(span)));
          s = longint'($urandom_range(0, 2000)) - 1000;
          bb = -s * c + longint'($urandom_range(0, 4000000)) - 1000000;
          k = 32'(s);
          b = 40'(bb);
        end
      endcase
    end else if (r < 92) begin
      op = OP_QUERY;
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          case ($urandom_range(0, 3))
            0: x = 17'd0;
            1: x = 17'd1;
            2: x = 17'(span);
            default: x = 17'(span + 1);
          endcase
        end
        default: x = 17'($urandom_range(1, 32'(span)));
      endcase
    end else begin
      op = OP_NOP;
    end
    send_item(op, k, b, x, 1'b0, '0);
  endtask

  // Bring the block to rest: every result in, every walk finished and any
  // clearing sweep done.
  task automatic settle();
    in_valid <= 1'b0;
    while (peak_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (cycle_no < last_clear_cycle + SWEEP_CYCLES) @(posedge clk);
  endtask

  // Write the domain register, then read it back over the same port.
  task automatic write_domain(input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * REG_DOMAIN_SIZE);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dom_reg = value[DOM_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== DATA_W'(value[DOM_W-1:0])) begin
      $display("%0t: domain_size read back: expected %0d, got %0d",
               $time, value[DOM_W-1:0], back);
      fault_count++;
    end
    n_settings++;
  endtask

  // Receiver: ready drops for random stretches, except in steady phases.
  always @(posedge clk) begin : result_sink
    int g;
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= g - 1;
      end
    end
  end

  // Every accepted result must match the oldest maximum still owed.
  always @(posedge clk) begin : result_check
    logic signed [VAL_W-1:0] owed;
    if (out_valid && out_ready) begin
      if (peak_queue.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, got %0d",
                 $time, max_value);
        fault_count++;
      end else begin
        owed = peak_queue.pop_front();
        n_checked++;
        if (max_value !== owed) begin
          $display("%0t: max_value mismatch: expected %0d, got %0d", $time, owed, max_value);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
      $display("max_line_segment_tree_unit_test: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] phase_dom [8];
    longint span;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid       <= 1'b0;
    func           <= OP_NOP;
    line_slope     <= '0;
    line_intercept <= '0;
    query_x        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. The first rows run at the reset domain of one; a domain
    // row waits for the block to come to rest before its write.
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == STEP_DOMAIN) begin
        settle();
        write_domain(SCRIPT[i].dom);
      end else begin
        send_item(SCRIPT[i].op, SCRIPT[i].k, SCRIPT[i].b, SCRIPT[i].x,
                  SCRIPT[i].pinned, SCRIPT[i].want);
      end
    end

    // Random phases, each under its own domain: the built size, the largest
    // register value, the smallest trees, and random sizes either side of
    // the built size.
    phase_dom[0] = 32'd65536;
    phase_dom[1] = 32'd131071;
    phase_dom[2] = 32'd1;
    phase_dom[3] = 32'd2;
    phase_dom[4] = 32'd3;
    phase_dom[5] = $urandom_range(4, 64);
    phase_dom[6] = $urandom_range(65, 65535);
    phase_dom[7] = $urandom_range(65537, 131070);
    for (int p = 0; p < 8; p++) begin
      settle();
      write_domain(phase_dom[p]);
      span = tree_span();
      // Two phases run without any idling on either side.
      steady_flow = (p == 2) || (p == 5);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // Halfway through, hold the sender until every result is in.
        if (j == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (peak_queue.size() != 0);
        end
        // A clear part-way into two phases, with the tree well filled.
        if ((p == 1 || p == 6) && j == 20) begin
          send_item(OP_CLEAR, $urandom, {8'($urandom), 32'($urandom)}, 17'($urandom),
                    1'b0, '0);
        end
        send_random(span);
      end
      steady_flow = 1'b0;
    end

    settle();
    $display("Covered %0d inserts, %0d queries, %0d clears and %0d unused operations",
             n_insert, n_query, n_clear, n_nop);
    $display("under %0d domain settings; %0d results compared, %0d faults",
             n_settings, n_checked, fault_count);
    if (fault_count == 0) begin
      $display("max_line_segment_tree_unit_test: done, clean");
    end else begin
      $display("max_line_segment_tree_unit_test: done, errors");
    end
    $finish;
  end

endmodule
